// ----- rtl/dbm_pkg.sv -----
// ============================================================================
// dbm_pkg
// Shared types and constants of the detection box merge block.
// ============================================================================
`default_nettype none

package dbm_pkg;

    localparam int COORD_W   = 24;
    localparam int OFFSET_W  = 16;
    localparam int SCORE_W   = 16;
    localparam int CLASS_W   = 2;
    localparam int GRID_W    = 8;
    localparam int CELLSZ_W  = 8;
    localparam int REG_IDX_W = 2;
    localparam int REG_DATA_W = 16;

    // command queue between front and back part
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CELL_WIDTH  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_CELL_HEIGHT = 2'd2;

    localparam logic [SCORE_W-1:0]  THRESHOLD_RST   = 16'd32768;
    localparam logic [CELLSZ_W-1:0] CELL_WIDTH_RST  = 8'd16;
    localparam logic [CELLSZ_W-1:0] CELL_HEIGHT_RST = 8'd16;

    typedef enum logic {
        OP_CELL      = 1'b0,
        OP_FRAME_END = 1'b1
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic [SCORE_W-1:0]         coverage;
        logic signed [OFFSET_W-1:0] left_offset;
        logic signed [OFFSET_W-1:0] top_offset;
        logic signed [OFFSET_W-1:0] right_offset;
        logic signed [OFFSET_W-1:0] bottom_offset;
        logic [GRID_W-1:0]          cell_col;
        logic [GRID_W-1:0]          cell_row;
        logic [CLASS_W-1:0]         class_id;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_left;
        logic signed [COORD_W-1:0] out_top;
        logic signed [COORD_W-1:0] out_right;
        logic signed [COORD_W-1:0] out_bottom;
        logic [SCORE_W-1:0]        out_score;
        logic [CLASS_W-1:0]        out_class;
        logic                      no_boxes;
        logic                      dropped;
        logic                      last;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic signed [COORD_W-1:0] right;
        logic signed [COORD_W-1:0] bottom;
        logic [SCORE_W-1:0]        score;
        logic [CLASS_W-1:0]        cls;
    } box_t;

    typedef struct packed {
        op_t  op;
        box_t box;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT_RD,
        ST_EMIT_LD
    } back_state_t;

endpackage

`default_nettype wire

// ----- rtl/dbm_front.sv -----
// ============================================================================
// dbm_front
// Config registers, score/class filter and box edge computation.
// ============================================================================
`default_nettype none

module dbm_front #(
    parameter int NUM_CLASSES = 4
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  wr_en,
    input  wire  [dbm_pkg::REG_IDX_W-1:0]        wr_index,
    input  wire  [dbm_pkg::REG_DATA_W-1:0]       wr_data,
    input  wire                                  push,
    output logic                                 full,
    input  dbm_pkg::in_item_t                    item,
    input  wire                                  q_full,
    output logic                                 q_push,
    output dbm_pkg::cmd_t                        q_data
);
    import dbm_pkg::*;

    localparam logic [CLASS_W:0] NumCls = (CLASS_W+1)'(NUM_CLASSES);

    logic [SCORE_W-1:0]        thr_reg;
    logic [CELLSZ_W-1:0]       cw_reg;
    logic [CELLSZ_W-1:0]       ch_reg;
    logic                      s1_valid_reg;
    in_item_t                  s1_item_reg;
    logic [GRID_W+CELLSZ_W-1:0] mx_reg;
    logic [GRID_W+CELLSZ_W-1:0] my_reg;
    logic                      s1_free;
    logic                      keep;
    logic [COORD_W-1:0]        ox;
    logic [COORD_W-1:0]        oy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESHOLD_RST;
            cw_reg  <= CELL_WIDTH_RST;
            ch_reg  <= CELL_HEIGHT_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_THRESHOLD:   thr_reg <= wr_data;
                REG_CELL_WIDTH:  cw_reg  <= wr_data[CELLSZ_W-1:0];
                REG_CELL_HEIGHT: ch_reg  <= wr_data[CELLSZ_W-1:0];
                default:         ;
            endcase
        end
    end

    assign s1_free = !s1_valid_reg || !q_full;
    assign full    = !s1_free;

    // cells at or below threshold or of an unsupported class never enter the queue
    assign keep = (item.op == OP_FRAME_END) ||
                  ((item.coverage > thr_reg) && ({1'b0, item.class_id} < NumCls));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_reg <= push && keep;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && push)
        begin
            s1_item_reg <= item;
            mx_reg      <= (GRID_W+CELLSZ_W)'(item.cell_col) *
                           (GRID_W+CELLSZ_W)'(cw_reg);
            my_reg      <= (GRID_W+CELLSZ_W)'(item.cell_row) *
                           (GRID_W+CELLSZ_W)'(ch_reg);
        end
    end

    // cell origin in Q.4
    assign ox = COORD_W'({mx_reg, 4'b0000});
    assign oy = COORD_W'({my_reg, 4'b0000});

    always_comb
    begin
        q_push           = s1_valid_reg && !q_full;
        q_data.op        = s1_item_reg.op;
        q_data.box.left   = COORD_W'($signed(s1_item_reg.left_offset)) + ox;
        q_data.box.top    = COORD_W'($signed(s1_item_reg.top_offset)) + oy;
        q_data.box.right  = COORD_W'($signed(s1_item_reg.right_offset)) + ox;
        q_data.box.bottom = COORD_W'($signed(s1_item_reg.bottom_offset)) + oy;
        q_data.box.score  = s1_item_reg.coverage;
        q_data.box.cls    = s1_item_reg.class_id;
    end

endmodule

`default_nettype wire

// ----- rtl/dbm_queue.sv -----
// ============================================================================
// dbm_queue
// Short command queue decoupling the front and back parts.
// ============================================================================
`default_nettype none

module dbm_queue (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            wr,
    input  dbm_pkg::cmd_t  wr_data,
    output logic           q_full,
    input  wire            rd,
    output dbm_pkg::cmd_t  rd_data,
    output logic           q_empty
);
    import dbm_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg;
    logic [QPTR_W-1:0] rptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_wr;
    logic              do_rd;

    assign q_full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign rd_data = slot_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= wptr_reg + QPTR_W'(1);
            end
            if (do_rd)
            begin
                rptr_reg <= rptr_reg + QPTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/dbm_back.sv -----
// ============================================================================
// dbm_back
// Box table: scans for an overlapping box, merges or appends, emits at frame end.
// ============================================================================
`default_nettype none

module dbm_back #(
    parameter int MAX_BOXES = 32
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  dbm_pkg::cmd_t       q_head,
    input  wire                 q_empty,
    output logic                q_pop,
    output logic                empty,
    input  wire                 pop,
    output dbm_pkg::out_item_t  result
);
    import dbm_pkg::*;

    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam logic [CW-1:0] MaxCnt = CW'(MAX_BOXES);

    box_t        mem [MAX_BOXES];
    box_t        rd_data_reg;
    logic [IW-1:0] rd_addr;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    box_t          mem_wdata;

    back_state_t state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    box_t          cur_reg, cur_next;
    out_item_t     res_reg, res_next;
    logic          res_valid_reg, res_valid_next;

    logic          out_free;
    logic [CW-1:0] idx_inc;
    logic          apart;
    logic          hit;
    box_t          merged;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign out_free = !res_valid_reg || pop;
    assign idx_inc  = idx_reg + CW'(1);

    // touching edges count as overlap
    assign apart = ($signed(cur_reg.left)   > $signed(rd_data_reg.right))  ||
                   ($signed(cur_reg.right)  < $signed(rd_data_reg.left))   ||
                   ($signed(cur_reg.top)    > $signed(rd_data_reg.bottom)) ||
                   ($signed(cur_reg.bottom) < $signed(rd_data_reg.top));
    assign hit = (rd_data_reg.cls == cur_reg.cls) && !apart;

    always_comb
    begin
        merged = rd_data_reg;
        if ($signed(cur_reg.left) < $signed(rd_data_reg.left))
        begin
            merged.left = cur_reg.left;
        end
        if ($signed(cur_reg.top) < $signed(rd_data_reg.top))
        begin
            merged.top = cur_reg.top;
        end
        if ($signed(cur_reg.right) > $signed(rd_data_reg.right))
        begin
            merged.right = cur_reg.right;
        end
        if ($signed(cur_reg.bottom) > $signed(rd_data_reg.bottom))
        begin
            merged.bottom = cur_reg.bottom;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        cur_next       = cur_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !pop;
        q_pop          = 1'b0;
        rd_addr        = '0;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[IW-1:0];
        mem_wdata      = cur_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_head.op == OP_CELL)
                    begin
                        q_pop    = 1'b1;
                        cur_next = q_head.box;
                        if (count_reg == '0)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = '0;
                            mem_wdata  = q_head.box;
                            count_next = CW'(1);
                        end
                        else
                        begin
                            // entry 0 is being read this cycle
                            idx_next   = '0;
                            state_next = ST_SCAN;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        if (out_free)
                        begin
                            q_pop          = 1'b1;
                            res_next       = '0;
                            res_next.no_boxes = 1'b1;
                            res_next.dropped  = ovf_reg;
                            res_next.last     = 1'b1;
                            res_valid_next = 1'b1;
                            ovf_next       = 1'b0;
                        end
                    end
                    else
                    begin
                        q_pop      = 1'b1;
                        idx_next   = '0;
                        state_next = ST_EMIT_RD;
                    end
                end
            end

            ST_SCAN:
            begin
                rd_addr = idx_inc[IW-1:0];
                if (hit)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = idx_reg[IW-1:0];
                    mem_wdata  = merged;
                    state_next = ST_IDLE;
                end
                else if (idx_inc == count_reg)
                begin
                    if (count_reg < MaxCnt)
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end

            ST_EMIT_RD:
            begin
                rd_addr    = idx_reg[IW-1:0];
                state_next = ST_EMIT_LD;
            end

            ST_EMIT_LD:
            begin
                rd_addr = idx_reg[IW-1:0];
                if (out_free)
                begin
                    res_next.out_left   = rd_data_reg.left;
                    res_next.out_top    = rd_data_reg.top;
                    res_next.out_right  = rd_data_reg.right;
                    res_next.out_bottom = rd_data_reg.bottom;
                    res_next.out_score  = rd_data_reg.score;
                    res_next.out_class  = rd_data_reg.cls;
                    res_next.no_boxes   = 1'b0;
                    res_next.dropped    = ovf_reg;
                    res_next.last       = (idx_inc == count_reg);
                    res_valid_next      = 1'b1;
                    if (idx_inc == count_reg)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        res_reg <= res_next;
    end

    assign empty  = !res_valid_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

// ----- rtl/detection_box_merge.sv -----
// ============================================================================
// detection_box_merge
// Clusters per-cell box proposals into merged boxes per class, emitted at frame end.
// ============================================================================
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------
//  config   | wr_en              | wr_index, wr_data
//  input    | push / full        | item   (in_item_t)
//  result   | empty / pop        | result (out_item_t)
//
//  Input takes one item per cycle while full is low, into a one-stage front and a
//  4-entry queue. A kept cell is written straight into an empty table; otherwise the
//  back part scans for an overlap, one box memory read per cycle.
//  At frame end each stored box takes a memory read, then the result register, which
//  waits while the previous result has not been popped.
//  Reset clears state, index, counts and flags only; the box memory needs no clearing pass.
//  Full rises when the front stage and queue are both occupied.
// ============================================================================
`default_nettype none

module detection_box_merge #(
    parameter int MAX_BOXES   = 32,
    parameter int NUM_CLASSES = 4
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             wr_en,
    input  wire  [dbm_pkg::REG_IDX_W-1:0]   wr_index,
    input  wire  [dbm_pkg::REG_DATA_W-1:0]  wr_data,
    input  wire                             push,
    output logic                            full,
    input  dbm_pkg::in_item_t               item,
    output logic                            empty,
    input  wire                             pop,
    output dbm_pkg::out_item_t              result
);
    import dbm_pkg::*;

    logic q_push;
    cmd_t q_wdata;
    logic q_full;
    logic q_pop;
    cmd_t q_head;
    logic q_empty;

    dbm_front #(
        .NUM_CLASSES (NUM_CLASSES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .push     (push),
        .full     (full),
        .item     (item),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    dbm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_push),
        .wr_data (q_wdata),
        .q_full  (q_full),
        .rd      (q_pop),
        .rd_data (q_head),
        .q_empty (q_empty)
    );

    dbm_back #(
        .MAX_BOXES (MAX_BOXES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_head  (q_head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

`default_nettype wire
